// File: design/text_mode_terminal_writer_core_macros.svh
// ----------------------------------------------------------------------------
// Terminal writer assertion macros
// Clocked assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// assertion with reset qualification
`define TMTW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion that also holds during reset
`define TMTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMTW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMTW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// Terminal writer package
// Screen geometry, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W         = $clog2(CELL_COUNT);

    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int NUM_W     = 32;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int POS_W     = 11;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;
    localparam int DIG_N     = 10;
    localparam int DIG_W     = 4;
    localparam int DIG_IDX_W = $clog2(DIG_N);
    localparam int BCD_W     = DIG_N * DIG_W;
    localparam int BIT_CNT_W = $clog2(NUM_W);

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F00;
    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    localparam int                  CFG_ADDR_W = 3;
    localparam logic [COLOR_W-1:0]  FG_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0]  BG_RESET   = 4'h0;

    typedef enum logic [0:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } t_reg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR     = 3'd0,
        OP_PUT_UNSIGNED = 3'd1,
        OP_PUT_SIGNED   = 3'd2,
        OP_SET_CURSOR   = 3'd3,
        OP_CLEAR        = 3'd4,
        OP_READ_CELL    = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        W_NONE,
        W_CHAR,
        W_BLANK_ALL,
        W_BLANK_ROW,
        W_COPY
    } t_wsel;

    typedef enum logic [1:0] {
        R_NONE,
        R_COPY,
        R_CELL
    } t_rsel;

    typedef enum logic [1:0] {
        BYTE_CHAR,
        BYTE_MINUS,
        BYTE_DIGIT
    } t_byte_sel;

    typedef struct packed {
        logic      load;
        logic      bcd_load;
        logic      bcd_negate;
        logic      bcd_step;
        logic      dig_init;
        logic      dig_dec;
        logic      byte_load;
        t_byte_sel byte_sel;
        logic      cur_inc;
        logic      cur_lb;
        logic      cur_set;
        logic      walk_clr;
        logic      walk_inc;
        t_wsel     wsel;
        t_rsel     rsel;
        logic      set_err;
        logic      cap_cell;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            is_newline;
        logic            num_neg;
        logic            pos_bad;
        logic            col_last;
        logic            row_last;
        logic            bcd_last;
        logic            dig_zero;
        logic            dig_is0;
        logic            walk_end_cell;
        logic            walk_end_col;
        logic            walk_end_scroll;
    } t_status;

endpackage

// File: design/tmtw_ctrl.sv
// ----------------------------------------------------------------------------
// Terminal writer controller
// Sequences decode, number conversion, cell writes, scroll and clear walks.
// ----------------------------------------------------------------------------
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_free,
    output logic    o_finish,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_CONV,
        S_SKIP,
        S_DIGIT,
        S_EMIT,
        S_LB,
        S_SCROLL,
        S_BLANK,
        S_NEXT,
        S_CLEAR,
        S_RWAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_num_mode, n_num_mode;
    logic   r_last, n_last;
    logic   r_neg, n_neg;
    logic   w_neg_print;

    assign w_neg_print = (t_opcode'(i_status.opcode) == OP_PUT_SIGNED) && i_status.num_neg;

    always_comb begin
        n_state    = r_state;
        n_num_mode = r_num_mode;
        n_last     = r_last;
        n_neg      = r_neg;
        o_cmd      = '0;
        o_cmd.wsel = W_NONE;
        o_cmd.rsel = R_NONE;
        o_cmd.byte_sel = BYTE_CHAR;
        o_in_ready = 1'b0;
        o_finish   = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wsel = W_BLANK_ALL;
                if (i_status.walk_end_cell) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_num_mode = 1'b0;
                n_last     = 1'b1;
                n_neg      = 1'b0;
                case (t_opcode'(i_status.opcode))
                    OP_PUT_CHAR: begin
                        if (i_status.is_newline) begin
                            n_state = S_LB;
                        end else begin
                            o_cmd.byte_load = 1'b1;
                            o_cmd.byte_sel  = BYTE_CHAR;
                            n_state         = S_EMIT;
                        end
                    end
                    OP_PUT_UNSIGNED, OP_PUT_SIGNED: begin
                        o_cmd.bcd_load   = 1'b1;
                        o_cmd.bcd_negate = w_neg_print;
                        o_cmd.dig_init   = 1'b1;
                        n_num_mode       = 1'b1;
                        n_neg            = w_neg_print;
                        n_state          = S_CONV;
                    end
                    OP_SET_CURSOR: begin
                        if (i_status.pos_bad) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.cur_set = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    OP_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    OP_READ_CELL: begin
                        if (i_status.pos_bad) begin
                            o_cmd.set_err = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.rsel = R_CELL;
                            n_state    = S_RWAIT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CONV: begin
                o_cmd.bcd_step = 1'b1;
                if (i_status.bcd_last) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.dig_zero && !i_status.dig_is0) begin
                    o_cmd.dig_dec = 1'b1;
                end else if (r_neg) begin
                    o_cmd.byte_load = 1'b1;
                    o_cmd.byte_sel  = BYTE_MINUS;
                    n_neg           = 1'b0;
                    n_last          = 1'b0;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_cmd.byte_load = 1'b1;
                o_cmd.byte_sel  = BYTE_DIGIT;
                o_cmd.dig_dec   = !i_status.dig_is0;
                n_last          = i_status.dig_is0;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.wsel = W_CHAR;
                if (i_status.col_last) begin
                    n_state = S_LB;
                end else begin
                    o_cmd.cur_inc = 1'b1;
                    n_state       = S_NEXT;
                end
            end
            S_LB: begin
                o_cmd.cur_lb   = 1'b1;
                o_cmd.walk_clr = 1'b1;
                n_state        = i_status.row_last ? S_SCROLL : S_BLANK;
            end
            S_SCROLL: begin
                // read one row ahead, write the word read in the cycle before
                o_cmd.wsel = W_COPY;
                if (i_status.walk_end_scroll) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_BLANK;
                end else begin
                    o_cmd.rsel     = R_COPY;
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_BLANK: begin
                o_cmd.wsel = W_BLANK_ROW;
                if (i_status.walk_end_col) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_NEXT;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_NEXT: begin
                n_state = (r_num_mode && !r_last) ? S_DIGIT : S_DONE;
            end
            S_CLEAR: begin
                o_cmd.wsel = W_BLANK_ALL;
                if (i_status.walk_end_cell) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_RWAIT: begin
                o_cmd.cap_cell = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_num_mode <= 1'b0;
            r_last     <= 1'b0;
            r_neg      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_num_mode <= n_num_mode;
            r_last     <= n_last;
            r_neg      <= n_neg;
        end
    end

endmodule

// File: design/tmtw_dp.sv
// ----------------------------------------------------------------------------
// Terminal writer datapath
// Cell memory, cursor, walk counter and shift-add-3 decimal converter.
// ----------------------------------------------------------------------------
`include "text_mode_terminal_writer_core_macros.svh"

module tmtw_dp
    import tmtw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [NUM_W-1:0]  i_number_value,
    input  logic [COL_W-1:0]  i_column,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [ATTR_W-1:0] i_attr,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [POS_W-1:0]  o_cursor_position,
    output logic [CELL_W-1:0] o_cell_data,
    output logic              o_range_error
);

    // latched request
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [NUM_W-1:0]  r_num;
    logic [COL_W-1:0]  r_col_in;
    logic [ROW_W-1:0]  r_row_in;

    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ADDR_W-1:0] r_walk;
    logic [CHAR_W-1:0] r_byte;
    logic [CELL_W-1:0] r_cell_out;
    logic              r_err;

    logic [NUM_W-1:0]     r_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [DIG_IDX_W-1:0] r_dig;
    logic [DIG_W-1:0]     w_digit;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    logic [ADDR_W-1:0] w_row_base, w_cur_addr, w_in_addr;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_we, w_re;

    assign w_row_base = ADDR_W'(r_cur_row) * ADDR_W'(SCREEN_COLUMNS);
    assign w_cur_addr = w_row_base + ADDR_W'(r_cur_col);
    assign w_in_addr  = ADDR_W'(r_row_in) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(r_col_in);
    assign w_digit    = r_bcd[r_dig*DIG_W +: DIG_W];

    always_comb begin
        w_we    = 1'b1;
        w_waddr = w_cur_addr;
        w_wdata = {i_attr, r_byte};
        case (i_cmd.wsel)
            W_CHAR: begin
                w_waddr = w_cur_addr;
                w_wdata = {i_attr, r_byte};
            end
            W_BLANK_ALL: begin
                w_waddr = r_walk;
                w_wdata = BLANK_CELL;
            end
            W_BLANK_ROW: begin
                w_waddr = w_row_base + r_walk;
                w_wdata = BLANK_CELL;
            end
            W_COPY: begin
                w_we    = (r_walk != '0);
                w_waddr = r_walk - ADDR_W'(1);
                w_wdata = r_rdata;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_re    = 1'b1;
        w_raddr = w_in_addr;
        case (i_cmd.rsel)
            R_COPY:  w_raddr = r_walk + ADDR_W'(SCREEN_COLUMNS);
            R_CELL:  w_raddr = w_in_addr;
            default: w_re    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // shift-add-3: correct each digit, then shift in the next binary bit
    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int d = 0; d < DIG_N; d++) begin
            if (r_bcd[d*DIG_W +: DIG_W] >= DIG_W'(5)) begin
                adj[d*DIG_W +: DIG_W] = r_bcd[d*DIG_W +: DIG_W] + DIG_W'(3);
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[NUM_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_char   <= i_char_code;
            r_num    <= i_number_value;
            r_col_in <= i_column;
            r_row_in <= i_row;
        end
        if (i_cmd.bcd_load) begin
            r_bin <= i_cmd.bcd_negate ? (~r_num + NUM_W'(1)) : r_num;
            r_bcd <= '0;
        end else if (i_cmd.bcd_step) begin
            r_bin <= {r_bin[NUM_W-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
        if (i_cmd.dig_init) begin
            r_dig <= DIG_IDX_W'(DIG_N - 1);
        end else if (i_cmd.dig_dec) begin
            r_dig <= r_dig - DIG_IDX_W'(1);
        end
        if (i_cmd.byte_load) begin
            case (i_cmd.byte_sel)
                BYTE_MINUS: r_byte <= CHAR_MINUS;
                BYTE_DIGIT: r_byte <= CHAR_ZERO + CHAR_W'(w_digit);
                default:    r_byte <= r_char;
            endcase
        end
        if (i_cmd.load) begin
            r_cell_out <= '0;
            r_err      <= 1'b0;
        end else begin
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.cap_cell) begin
                r_cell_out <= r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_walk    <= '0;
            r_bit_cnt <= '0;
        end else begin
            if (i_cmd.cur_set) begin
                r_cur_col <= r_col_in;
                r_cur_row <= r_row_in;
            end else if (i_cmd.cur_lb) begin
                r_cur_col <= '0;
                if (!o_status.row_last) begin
                    r_cur_row <= r_cur_row + ROW_W'(1);
                end
            end else if (i_cmd.cur_inc) begin
                r_cur_col <= r_cur_col + COL_W'(1);
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + ADDR_W'(1);
            end
            if (i_cmd.bcd_load) begin
                r_bit_cnt <= '0;
            end else if (i_cmd.bcd_step) begin
                r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_status.opcode     = r_op;
        o_status.is_newline = (r_char == NEWLINE_BYTE);
        o_status.num_neg    = r_num[NUM_W-1];
        o_status.pos_bad    = ({1'b0, r_col_in} >= (COL_W+1)'(SCREEN_COLUMNS))
                           || ({1'b0, r_row_in} >= (ROW_W+1)'(SCREEN_ROWS));
        o_status.col_last   = (r_cur_col == COL_W'(SCREEN_COLUMNS - 1));
        o_status.row_last   = (r_cur_row == ROW_W'(SCREEN_ROWS - 1));
        o_status.bcd_last   = (r_bit_cnt == BIT_CNT_W'(NUM_W - 1));
        o_status.dig_zero   = (w_digit == '0);
        o_status.dig_is0    = (r_dig == '0);
        o_status.walk_end_cell   = (r_walk == ADDR_W'(CELL_COUNT - 1));
        o_status.walk_end_col    = (r_walk == ADDR_W'(SCREEN_COLUMNS - 1));
        o_status.walk_end_scroll = (r_walk == ADDR_W'(CELL_COUNT - SCREEN_COLUMNS));
    end

    assign o_cursor_column   = r_cur_col;
    assign o_cursor_row      = r_cur_row;
    assign o_cursor_position = POS_W'(w_cur_addr);
    assign o_cell_data       = r_cell_out;
    assign o_range_error     = r_err;

    `TMTW_ASSERT(a_cursor_on_screen, i_clk, i_rst_n, ({1'b0, r_cur_col} < (COL_W+1)'(SCREEN_COLUMNS)) && ({1'b0, r_cur_row} < (ROW_W+1)'(SCREEN_ROWS)), "cursor left the screen")
    `TMTW_ASSERT(a_copy_read_in_range, i_clk, i_rst_n, (i_cmd.rsel == R_COPY) |-> !o_status.walk_end_scroll, "scroll read past buffer end")
    `TMTW_ASSERT(a_bcd_wraps, i_clk, i_rst_n, (i_cmd.bcd_step && o_status.bcd_last) |=> (r_bit_cnt == '0), "bit counter did not finish on the last bit")
    `TMTW_ASSERT(a_cap_after_read, i_clk, i_rst_n, i_cmd.cap_cell |-> ($past(i_cmd.rsel) == R_CELL), "cell captured without a read")

endmodule

// File: design/text_mode_terminal_writer_core.sv
// ----------------------------------------------------------------------------
// Text-mode terminal writer core
// Usage:
//   Requests enter on i_valid/o_stall (opcode, char, number, column, row);
//   each transaction yields exactly one result transaction on o_valid/i_stall
//   carrying the cursor, the linear cursor position, cell data and a range
//   flag. Colors are set through the APB port (foreground at 0x0, background
//   at 0x4) by the user while the block is idle; the block does not enforce it.
// Work per request follows the controller sequence and the single write
// port of the cell memory: a line break also blanks the new row; on the
// last row the scroll copy first moves every row up by one (one cell per
// cycle); clear blanks every cell in turn; decimal print runs the
// shift-add-3 conversion over all 32 bits, skips leading zero digits, then
// writes the printed characters one at a time.
// One request is worked at a time; the next is taken once the previous result
// sits in the output register, even if the receiver still stalls it.
// Reset: cursor goes to 0,0 and a blanking sweep over every cell fills
// the buffer with 0x0F00; o_stall stays high during that sweep.
// A stalled result holds its payload until taken.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core
    import tmtw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [NUM_W-1:0]      i_number_value,
    input  logic [COL_W-1:0]      i_column,
    input  logic [ROW_W-1:0]      i_row,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COL_W-1:0]      o_cursor_column,
    output logic [ROW_W-1:0]      o_cursor_row,
    output logic [POS_W-1:0]      o_cursor_position,
    output logic [CELL_W-1:0]     o_cell_data,
    output logic                  o_range_error,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_finish;
    logic    w_out_free;

    // color registers
    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic               w_cfg_wr;
    t_reg_idx           w_reg_idx;

    // result register
    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic [POS_W-1:0]   r_out_pos;
    logic [CELL_W-1:0]  r_out_cell;
    logic               r_out_err;

    logic [COL_W-1:0]   w_dp_col;
    logic [ROW_W-1:0]   w_dp_row;
    logic [POS_W-1:0]   w_dp_pos;
    logic [CELL_W-1:0]  w_dp_cell;
    logic               w_dp_err;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        case (w_reg_idx)
            REG_FOREGROUND: prdata = 32'(r_fg);
            REG_BACKGROUND: prdata = 32'(r_bg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_FOREGROUND: r_fg <= pwdata[COLOR_W-1:0];
                REG_BACKGROUND: r_bg <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // the controller only takes a new request in its idle state
    assign o_stall    = !w_in_ready;
    assign w_out_free = !r_out_valid || !i_stall;

    tmtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (w_in_ready),
        .i_out_free (w_out_free),
        .o_finish   (w_finish),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tmtw_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_number_value    (i_number_value),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_attr            ({r_bg, r_fg}),
        .o_cursor_column   (w_dp_col),
        .o_cursor_row      (w_dp_row),
        .o_cursor_position (w_dp_pos),
        .o_cell_data       (w_dp_cell),
        .o_range_error     (w_dp_err)
    );

    // result register: loaded when the controller finishes, drained by receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_col  <= w_dp_col;
            r_out_row  <= w_dp_row;
            r_out_pos  <= w_dp_pos;
            r_out_cell <= w_dp_cell;
            r_out_err  <= w_dp_err;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_cell;
    assign o_range_error     = r_out_err;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Terminal writer core testbench
// Drives random and directed requests, predicts cursor, cell reads and the
// screen buffer contents, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tmtw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request as queued for the driver
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CHAR_W-1:0] char_code;
        logic [NUM_W-1:0]  number_value;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_request;

    // cursor/cell result
    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
        logic              range_error;
    } t_cursor_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [OP_W-1:0]       i_opcode = '0;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [NUM_W-1:0]      i_number_value = '0;
    logic [COL_W-1:0]      i_column = '0;
    logic [ROW_W-1:0]      i_row = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [COL_W-1:0]      o_cursor_column;
    logic [ROW_W-1:0]      o_cursor_row;
    logic [POS_W-1:0]      o_cursor_position;
    logic [CELL_W-1:0]     o_cell_data;
    logic                  o_range_error;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    always #2 i_clk = ~i_clk;

    text_mode_terminal_writer_core dut (.*);

    // ------------------------------------------------------------------
    // Screen predictor: private copy of buffer, cursor and colors
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  screen [CELL_COUNT];
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    t_request       pending_requests[$];
    t_cursor_report expected_reports[$];
    int             error_count = 0;
    bit             hold_requests = 1'b0;
    bit             drain_stalls = 1'b0;

    task automatic blank_screen_row(input int r);
        for (int c = 0; c < SCREEN_COLUMNS; c++) screen[r*SCREEN_COLUMNS + c] = BLANK_CELL;
    endtask

    task automatic break_line();
        cur_col = '0;
        if (cur_row >= SCREEN_ROWS - 1) begin
            // scroll: everything moves up one row
            for (int i = 0; i + SCREEN_COLUMNS < CELL_COUNT; i++)
                screen[i] = screen[i + SCREEN_COLUMNS];
            blank_screen_row(SCREEN_ROWS - 1);
        end else begin
            cur_row = cur_row + 1'b1;
        end
        blank_screen_row(cur_row);
    endtask

    task automatic print_byte(input logic [CHAR_W-1:0] ch);
        if (ch == NEWLINE_BYTE) begin
            break_line();
        end else begin
            screen[cur_row*SCREEN_COLUMNS + cur_col] = {bg_color, fg_color, ch};
            cur_col = cur_col + 1'b1;
            if (cur_col >= SCREEN_COLUMNS) break_line();
        end
    endtask

    task automatic print_decimal(input logic [NUM_W-1:0] v);
        logic [CHAR_W-1:0] digs[$];
        if (v == 0) begin
            print_byte(CHAR_ZERO);
        end else begin
            while (v != 0) begin
                digs.push_front(CHAR_ZERO + CHAR_W'(v % 10));
                v = v / 10;
            end
            foreach (digs[k]) print_byte(digs[k]);
        end
    endtask

    function automatic bit off_screen(input t_request rq);
        return rq.column >= SCREEN_COLUMNS || rq.row >= SCREEN_ROWS;
    endfunction

    task automatic predict_request(input t_request rq);
        t_cursor_report rep;
        rep = '0;
        case (rq.opcode)
            OP_PUT_CHAR:     print_byte(rq.char_code);
            OP_PUT_UNSIGNED: print_decimal(rq.number_value);
            OP_PUT_SIGNED: begin
                if (rq.number_value[NUM_W-1]) begin
                    print_byte(CHAR_MINUS);
                    print_decimal(-rq.number_value);
                end else begin
                    print_decimal(rq.number_value);
                end
            end
            OP_SET_CURSOR: begin
                if (off_screen(rq)) begin
                    rep.range_error = 1'b1;
                end else begin
                    cur_col = rq.column;
                    cur_row = rq.row;
                end
            end
            OP_CLEAR: for (int r = 0; r < SCREEN_ROWS; r++) blank_screen_row(r);
            OP_READ_CELL: begin
                if (off_screen(rq)) rep.range_error = 1'b1;
                else rep.cell_data = screen[rq.row*SCREEN_COLUMNS + rq.column];
            end
            default: ;
        endcase
        rep.cursor_column   = cur_col;
        rep.cursor_row      = cur_row;
        rep.cursor_position = POS_W'(cur_row * SCREEN_COLUMNS + cur_col);
        expected_reports.push_back(rep);
    endtask

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: requests from the queue; gaps only between transactions
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_request({i_opcode, i_char_code, i_number_value, i_column, i_row});
                send_gap = gap_len();
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0 || hold_requests || pending_requests.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_valid <= 1'b0;
                end else begin
                    t_request rq;
                    rq = pending_requests.pop_front();
                    i_valid        <= 1'b1;
                    i_opcode       <= rq.opcode;
                    i_char_code    <= rq.char_code;
                    i_number_value <= rq.number_value;
                    i_column       <= rq.column;
                    i_row          <= rq.row;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall, compare each result with the oldest expected
    // ------------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_cursor_report got, want;
                got = {o_cursor_column, o_cursor_row, o_cursor_position,
                       o_cell_data, o_range_error};
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.cursor_column !== want.cursor_column) begin
                        $display("%0t: cursor_column expected %0d actual %0d",
                                 $time, want.cursor_column, got.cursor_column);
                        error_count++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.cursor_row, got.cursor_row);
                        error_count++;
                    end
                    if (got.cursor_position !== want.cursor_position) begin
                        $display("%0t: cursor_position expected %0d actual %0d",
                                 $time, want.cursor_position, got.cursor_position);
                        error_count++;
                    end
                    if (got.cell_data !== want.cell_data) begin
                        $display("%0t: cell_data expected %h actual %h",
                                 $time, want.cell_data, got.cell_data);
                        error_count++;
                    end
                    if (got.range_error !== want.range_error) begin
                        $display("%0t: range_error expected %0b actual %0b",
                                 $time, want.range_error, got.range_error);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0 && !drain_stalls) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = drain_stalls ? 0 : gap_len();
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_request make_req(input logic [OP_W-1:0] op,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [NUM_W-1:0] num,
                                          input logic [COL_W-1:0] c,
                                          input logic [ROW_W-1:0] r);
        t_request rq;
        rq.opcode = op; rq.char_code = ch; rq.number_value = num;
        rq.column = c; rq.row = r;
        return rq;
    endfunction

    function automatic t_request random_req();
        t_request rq;
        int p;
        rq = make_req(OP_W'($urandom_range(0, 7)), CHAR_W'($urandom), $urandom,
                      COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
        p = $urandom_range(0, 99);
        if (p < 45) begin
            rq.opcode = OP_PUT_CHAR;
            if ($urandom_range(0, 9) == 0) rq.char_code = NEWLINE_BYTE;
        end else if (p < 55) rq.opcode = OP_PUT_UNSIGNED;
        else if (p < 65) rq.opcode = OP_PUT_SIGNED;
        else if (p < 77) rq.opcode = OP_SET_CURSOR;
        else if (p < 95) rq.opcode = OP_READ_CELL;
        else if (p < 96) rq.opcode = OP_CLEAR;
        // small numbers keep the output short most of the time
        if ($urandom_range(0, 2) != 0) rq.number_value = $urandom_range(0, 999);
        // mostly on-screen positions so reads hit written cells
        if ($urandom_range(0, 4) != 0) begin
            rq.column = COL_W'($urandom_range(0, SCREEN_COLUMNS - 1));
            rq.row    = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        end
        return rq;
    endfunction

    // wait until everything sent has been answered and the block is quiet
    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [COLOR_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= CFG_ADDR_W'(4 * idx); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_FOREGROUND) fg_color = v;
        else bg_color = v;
    endtask

    initial begin
        cur_col = '0; cur_row = '0; fg_color = FG_RESET; bg_color = BG_RESET;
        for (int i = 0; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every operation, special cases
        pending_requests.push_back(make_req(OP_PUT_CHAR, 8'h00, '0, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_CHAR, 8'hFF, '0, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_CHAR, NEWLINE_BYTE, '0, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_UNSIGNED, '0, 32'd0, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_UNSIGNED, '0, 32'hFFFF_FFFF, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_SIGNED, '0, 32'h8000_0000, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_SIGNED, '0, 32'hFFFF_FFFF, '0, '0));
        pending_requests.push_back(make_req(OP_PUT_SIGNED, '0, 32'h7FFF_FFFF, '0, '0));
        pending_requests.push_back(make_req(OP_READ_CELL, '0, '0, 7'd0, 5'd1));
        pending_requests.push_back(make_req(OP_READ_CELL, '0, '0, 7'd127, 5'd31));
        pending_requests.push_back(make_req(OP_SET_CURSOR, '0, '0, 7'd80, 5'd0));
        pending_requests.push_back(make_req(OP_SET_CURSOR, '0, '0, 7'd0, 5'd25));
        // last cell of the screen: wrap on the last row forces a scroll
        pending_requests.push_back(make_req(OP_SET_CURSOR, '0, '0, 7'd79, 5'd24));
        pending_requests.push_back(make_req(OP_PUT_CHAR, 8'h41, '0, '0, '0));
        pending_requests.push_back(make_req(OP_READ_CELL, '0, '0, 7'd79, 5'd23));
        pending_requests.push_back(make_req(OP_PUT_CHAR, NEWLINE_BYTE, '0, '0, '0));
        pending_requests.push_back(make_req(OP_READ_CELL, '0, '0, 7'd79, 5'd22));
        pending_requests.push_back(make_req(3'd6, '0, '0, '0, '0));
        pending_requests.push_back(make_req(3'd7, '0, '0, '0, '0));
        pending_requests.push_back(make_req(OP_CLEAR, '0, '0, '0, '0));
        pending_requests.push_back(make_req(OP_READ_CELL, '0, '0, 7'd79, 5'd24));
        wait_idle();

        // random phases, colors changed between them (extremes included)
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin apb_write(REG_FOREGROUND, 4'h0); apb_write(REG_BACKGROUND, 4'hF); end
                1: begin apb_write(REG_FOREGROUND, 4'hF); apb_write(REG_BACKGROUND, 4'h0); end
                default: begin
                    apb_write(REG_FOREGROUND, COLOR_W'($urandom_range(0, 15)));
                    apb_write(REG_BACKGROUND, COLOR_W'($urandom_range(0, 15)));
                end
            endcase
            for (int k = 0; k < 180; k++) begin
                pending_requests.push_back(random_req());
                // sender holds off until the pipe is empty
                if (ph == 2 && k == 90) begin
                    while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
                    hold_requests = 1'b1;
                    while (expected_reports.size() != 0) @(posedge i_clk);
                    hold_requests = 1'b0;
                end
            end
            // a stretch with no receiver stalls
            if (ph == 4) drain_stalls = 1'b1;
            wait_idle();
            drain_stalls = 1'b0;
        end

        if (error_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #60ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
